// ===== hw/rtl/feistel_sbox_block_cipher_top_defines.svh =====
// Assertion macros shared by the cipher RTL.
`ifndef FEISTEL_SBOX_BLOCK_CIPHER_TOP_DEFINES_SVH
`define FEISTEL_SBOX_BLOCK_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define FSBC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsbc: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define FSBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsbc: next-cycle check failed");
`else
`define FSBC_ASSERT_SAME(lbl, ante, cons)
`define FSBC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/fsbc_pkg.sv =====
// Package: round count, stage payload type, S-box table and round helpers.
package fsbc_pkg;

    localparam int ROUND_COUNT = 16;
    // Rotation amount is the round index modulo the 32-bit key width.
    localparam int ROT_W = 5;
    localparam logic [ROT_W-1:0] LAST_ROUND = ROT_W'(ROUND_COUNT - 1);

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [1:0] REG_CIPHER_KEY = 2'd0;

    typedef struct packed {
        logic        cmd;
        logic [31:0] left;
        logic [31:0] right;
    } fsbc_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
        8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
        8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
        8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
        8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
        8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
        8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
        8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
        8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
        8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
        8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
        8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
        8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
        8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
        8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
        8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
        8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
        8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
        8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
        8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
        8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
        8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
        8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
        8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
        8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
        8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
        8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
        8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
        8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
        8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
    };

    // Rotate a 32-bit word left.
    function automatic logic [31:0] rotl32(input logic [31:0] word,
                                           input logic [ROT_W-1:0] amount);
        logic [63:0] dbl;
        dbl = {word, word} << amount;
        return dbl[63:32];
    endfunction

    // Substitute each byte of a word through the S-box.
    function automatic logic [31:0] sbox_word(input logic [31:0] word);
        return {SBOX[word[31:24]], SBOX[word[23:16]], SBOX[word[15:8]], SBOX[word[7:0]]};
    endfunction

endpackage

// ===== hw/rtl/fsbc_round.sv =====
// One registered Feistel round stage with its own valid bit and stall logic.
module fsbc_round (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [fsbc_pkg::ROT_W-1:0]     round_num,
    input  logic [31:0]                    cipher_key,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fsbc_pkg::fsbc_item_t           in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fsbc_pkg::fsbc_item_t           out_item
);
    import fsbc_pkg::*;

    logic        vld_reg;
    logic        vld_next;
    fsbc_item_t  item_reg;
    fsbc_item_t  item_next;
    logic [31:0] round_key;
    logic [31:0] f_out;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        // Decryption walks the rounds backward.
        if (in_item.cmd == CMD_DECRYPT)
        begin
            round_key = rotl32(cipher_key, LAST_ROUND - round_num);
            f_out     = sbox_word(in_item.left ^ round_key);
            item_next.cmd   = in_item.cmd;
            item_next.left  = in_item.right ^ f_out;
            item_next.right = in_item.left;
        end
        else
        begin
            round_key = rotl32(cipher_key, round_num);
            f_out     = sbox_word(in_item.right ^ round_key);
            item_next.cmd   = in_item.cmd;
            item_next.left  = in_item.right;
            item_next.right = in_item.left ^ f_out;
        end
    end

    assign vld_next = in_ready ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Load only on a handshake; hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_item  = item_reg;

endmodule

// ===== hw/rtl/feistel_sbox_block_cipher_top.sv =====
// Top level of the 64-bit Feistel block cipher with AES S-box round function.
// The cipher is a 16-stage pipeline, one Feistel round per register stage, so
// a new item is taken every cycle as long as the output side keeps ready high.
// The round count of the package sets the number of stages; the throughput is
// one item per cycle while the output does not stall. cmd = 0 encrypts
// (rounds 0 to 15), cmd = 1 decrypts (rounds 15 down to 0); round key i is
// the 32-bit key rotated left by i. The last stage register is the output
// register: when the output stalls, each stage keeps its item and a stage
// with a free slot still takes one, so ready upstream is high whenever any
// bubble exists in front of it. The key is written over the APB port at
// addresses 0 to 3 and is read by every stage directly; change it only while no
// item is in flight. Reads at addresses 4 to 7 return zero.
`include "feistel_sbox_block_cipher_top_defines.svh"

module feistel_sbox_block_cipher_top (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [63:0] block_in,
    // Result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] block_out
);
    import fsbc_pkg::*;

    logic [31:0]            cipher_key_reg;
    logic [31:0]            cipher_key_next;
    logic                   key_write;
    logic [1:0]             reg_index;

    // chain_vld[i] / chain_item[i] feed stage i; index ROUND_COUNT is the output.
    logic [ROUND_COUNT:0]   chain_vld;
    logic [ROUND_COUNT:0]   chain_rdy;
    fsbc_item_t             chain_item [ROUND_COUNT+1];

    // ---------------- Configuration ----------------
    assign pready    = 1'b1;
    assign reg_index = {1'b0, paddr[2]};
    assign key_write = psel && penable && pwrite && (reg_index == REG_CIPHER_KEY);
    assign cipher_key_next = key_write ? pwdata : cipher_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
        end
        else
        begin
            cipher_key_reg <= cipher_key_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_CIPHER_KEY: prdata = cipher_key_reg;
            default:        prdata = '0;
        endcase
    end

    // ---------------- Round pipeline ----------------
    // Split the block: left half in the upper 32 bits.
    assign chain_vld[0]        = in_valid;
    assign in_ready            = chain_rdy[0];
    assign chain_item[0].cmd   = cmd;
    assign chain_item[0].left  = block_in[63:32];
    assign chain_item[0].right = block_in[31:0];

    for (genvar i = 0; i < ROUND_COUNT; i++)
    begin : g_round
        fsbc_round u_round (
            .clk        (clk),
            .rst_n      (rst_n),
            .round_num  (ROT_W'(i)),
            .cipher_key (cipher_key_reg),
            .in_valid   (chain_vld[i]),
            .in_ready   (chain_rdy[i]),
            .in_item    (chain_item[i]),
            .out_valid  (chain_vld[i+1]),
            .out_ready  (chain_rdy[i+1]),
            .out_item   (chain_item[i+1])
        );
    end

    // No final swap: halves go out as the last round leaves them.
    assign out_valid             = chain_vld[ROUND_COUNT];
    assign chain_rdy[ROUND_COUNT] = out_ready;
    assign block_out = {chain_item[ROUND_COUNT].left, chain_item[ROUND_COUNT].right};

    // ---------------- Assertions ----------------
    // An empty pipeline always takes an item.
    `FSBC_ASSERT_SAME(a_empty_ready, chain_vld[ROUND_COUNT:1] == '0, in_ready)
    // An accepted item lands in the first stage.
    `FSBC_ASSERT_NEXT(a_enter_stage0, in_valid && in_ready, chain_vld[1])
    // Input back-pressure means every stage is full and the output stalls.
    `FSBC_ASSERT_SAME(a_full_on_stall, !in_ready, (&chain_vld[ROUND_COUNT:1]) && !out_ready)
    // A fully stalled pipeline drops and invents nothing.
    `FSBC_ASSERT_NEXT(a_hold_on_stall, !in_ready, $stable(chain_vld[ROUND_COUNT:1]))

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the Feistel S-box block cipher: random stimulus, key phases, self-checking.
`timescale 1ns / 100ps

module tb_top;

    import fsbc_pkg::*;

    // Key register address and an address with no register behind it.
    localparam logic [2:0] KEY_ADDR    = 3'(4 * REG_CIPHER_KEY);
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    localparam int NUM_ROUNDS   = ROUND_COUNT;
    localparam int HOLD_CYCLES  = 128;
    localparam int PHASE_ITEMS  = 180;
    localparam int SETTLE_TICKS = 2 * ROUND_COUNT + 4;

    // AES field polynomial (low byte) and the affine constant of the S-box.
    localparam logic [7:0] GF_POLY  = 8'h1B;
    localparam logic [7:0] AFFINE_C = 8'h63;

    // Cipher predictor and result store. The S-box is rebuilt here from the
    // field inverse and the affine map, so it does not share the RTL table.
    class cipher_scoreboard;
        logic [31:0] key;
        logic [7:0]  sbox [256];
        logic [63:0] expected_q [$];
        int          errors;
        int          checked;
        int          n_enc;
        int          n_dec;

        function new();
            int x;
            int y;
            logic [7:0] inv;
            key     = '0;
            errors  = 0;
            checked = 0;
            n_enc   = 0;
            n_dec   = 0;
            for (x = 0; x < 256; x++)
            begin
                inv = 8'h00;
                for (y = 1; y < 256; y++)
                begin
                    if (gf_mul(8'(x), 8'(y)) == 8'h01)
                        inv = 8'(y);
                end
                sbox[x] = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3)
                          ^ rol8(inv, 4) ^ AFFINE_C;
            end
        endfunction

        function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
            logic [7:0] p;
            int k;
            p = '0;
            for (k = 0; k < 8; k++)
            begin
                if (b[k])
                    p ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
            end
            return p;
        endfunction

        function logic [7:0] rol8(logic [7:0] v, int n);
            return (v << n) | (v >> (8 - n));
        endfunction

        function logic [31:0] round_key(int idx);
            int s;
            s = idx & 31;
            if (s == 0)
                return key;
            return (key << s) | (key >> (32 - s));
        endfunction

        function logic [31:0] mix_half(logic [31:0] half, logic [31:0] rk);
            logic [31:0] x;
            x = half ^ rk;
            return {sbox[x[31:24]], sbox[x[23:16]], sbox[x[15:8]], sbox[x[7:0]]};
        endfunction

        function logic [63:0] cipher(logic c, logic [63:0] blk);
            logic [31:0] l;
            logic [31:0] r;
            logic [31:0] t;
            int i;
            l = blk[63:32];
            r = blk[31:0];
            for (i = 0; i < NUM_ROUNDS; i++)
            begin
                if (c == CMD_ENCRYPT)
                begin
                    t = r;
                    r = l ^ mix_half(r, round_key(i));
                    l = t;
                end
                else
                begin
                    t = l;
                    l = r ^ mix_half(l, round_key(NUM_ROUNDS - 1 - i));
                    r = t;
                end
            end
            return {l, r};
        endfunction

        function void set_key(logic [31:0] k);
            key = k;
        endfunction

        function void note_input(logic c, logic [63:0] blk);
            expected_q.push_back(cipher(c, blk));
            if (c == CMD_ENCRYPT)
                n_enc++;
            else
                n_dec++;
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $error("block_out with no item pending: expected none actual %h", got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                $error("block_out mismatch: expected %h actual %h", want, got);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [63:0] block_in;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] block_out;

    cipher_scoreboard sb;

    // Idle-mode flags: in burst mode a side draws no random idle gap.
    bit send_burst;
    bit recv_burst;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit hold_req;
    int key_settings;

    feistel_sbox_block_cipher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .block_in  (block_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .block_out (block_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: far above the slowest legal run (every item and every
    // result waiting out a full idle draw, plus the long hold and drains).
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", sb.pending());
        $display("FAIL");
        $finish;
    end

    // Result side: check every accepted item, then draw the stall before the
    // next one. A hold request overrides the draw with a long stretch.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_result(block_out);
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                stall_left = recv_burst ? 0 : $urandom_range(0, 4);
            end
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one item after a random gap; hold it until accepted. Valid stays
    // high on return so a back-to-back item needs no second assignment.
    task automatic send_item(input logic c, input logic [63:0] blk);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        block_in <= blk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(c, blk);
    endtask

    // Drop valid, then wait until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // APB write: setup, access, then idle with psel low before the next access.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // APB read of the key, compared with the predictor's copy.
    task automatic check_key_readback();
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= KEY_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (rd !== sb.key)
        begin
            sb.errors++;
            $error("cipher_key mismatch: expected %h actual %h", sb.key, rd);
        end
    endtask

    // Load a new key once the pipeline is empty; optionally poke the unused
    // address first, which must leave the key alone.
    task automatic load_key(input logic [31:0] k, input bit poke_unused);
        drain();
        if (poke_unused)
        begin
            apb_write(UNUSED_ADDR, ~k);
            check_key_readback();
        end
        apb_write(KEY_ADDR, k);
        sb.set_key(k);
        key_settings++;
        check_key_readback();
    endtask

    // Random items: mostly random blocks, many round trips through the
    // opposite direction, plus saturated halves and single-set or single-clear-bit blocks.
    task automatic send_random(input int n);
        int sent;
        int kind;
        logic c;
        logic [63:0] blk;
        logic [63:0] ct;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(0, 9);
            c    = 1'($urandom_range(0, 1));
            blk  = {$urandom, $urandom};
            if (kind >= 5 && kind <= 7)
            begin
                ct = sb.cipher(c, blk);
                send_item(c, blk);
                send_item(c == CMD_ENCRYPT ? CMD_DECRYPT : CMD_ENCRYPT, ct);
                sent += 2;
            end
            else
            begin
                if (kind == 8)
                begin
                    case ($urandom_range(0, 3))
                        0:       blk[63:32] = '0;
                        1:       blk[63:32] = '1;
                        2:       blk[31:0]  = '0;
                        default: blk[31:0]  = '1;
                    endcase
                end
                else if (kind == 9)
                begin
                    blk = 64'h1 << $urandom_range(0, 63);
                    if ($urandom_range(0, 1) == 1)
                        blk = ~blk;
                end
                send_item(c, blk);
                sent++;
            end
        end
    endtask

    // One key phase: load the key, then random items. Hold asks the receiver
    // to stall long while items keep coming; pause drains mid-phase.
    task automatic run_phase(input logic [31:0] k, input bit poke_unused,
                             input bit with_hold, input bit with_pause);
        load_key(k, poke_unused);
        if (with_hold)
            hold_req = 1'b1;
        if (with_pause)
        begin
            send_random(PHASE_ITEMS / 2);
            drain();
            send_random(PHASE_ITEMS / 2);
        end
        else
            send_random(PHASE_ITEMS);
    endtask

    // Directed items under the current key: field extremes, both commands,
    // and a round trip.
    task automatic send_directed();
        logic [63:0] pt;
        send_item(CMD_ENCRYPT, 64'h0);
        send_item(CMD_DECRYPT, 64'h0);
        send_item(CMD_ENCRYPT, '1);
        send_item(CMD_DECRYPT, '1);
        send_item(CMD_ENCRYPT, 64'h8000_0000_0000_0000);
        send_item(CMD_ENCRYPT, 64'h0000_0000_0000_0001);
        send_item(CMD_DECRYPT, 64'hFFFF_FFFF_0000_0000);
        send_item(CMD_DECRYPT, 64'h0000_0000_FFFF_FFFF);
        send_item(CMD_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(CMD_DECRYPT, 64'h5555_5555_5555_5555);
        pt = 64'h0123_4567_89AB_CDEF;
        send_item(CMD_ENCRYPT, pt);
        send_item(CMD_DECRYPT, sb.cipher(CMD_ENCRYPT, pt));
    endtask

    initial
    begin
        sb           = new();
        send_burst   = 1'b0;
        recv_burst   = 1'b0;
        hold_req     = 1'b0;
        key_settings = 1;

        // Drive every input to a known value from time zero.
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        cmd      <= CMD_ENCRYPT;
        block_in <= '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key is zero: confirm it, then run the directed items on it.
        check_key_readback();
        send_directed();

        // All-ones key: every rotation equals the key.
        load_key(32'hFFFF_FFFF, 1'b0);
        send_directed();

        // Wrap-around key through the rotations; the unused address is poked.
        run_phase(32'h8000_0001, 1'b1, 1'b0, 1'b0);
        // Single set bit; receiver holds off long so the pipeline backs up.
        run_phase(32'h0000_0001, 1'b0, 1'b1, 1'b0);
        // Random keys, one with a mid-phase drain of the sender.
        run_phase($urandom, 1'b0, 1'b0, 1'b1);
        run_phase($urandom, 1'b1, 1'b0, 1'b0);
        run_phase(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        // Back to the zero key.
        run_phase(32'h0000_0000, 1'b0, 1'b1, 1'b0);

        // Wait out the pipeline depth so any stray result is caught.
        drain();
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Checked %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings,",
                 sb.checked, sb.n_enc, sb.n_dec, key_settings);
        $display("with random gaps, back-pressure and round trips in both directions.");
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
